/* sv/cla_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the CR/LF line assembler.
package cla_pkg;

  // Input beat opcodes
  typedef enum logic [2:0] {
    OP_BYTE  = 3'd0,
    OP_TICK  = 3'd1,
    OP_START = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_LINE_SIZE = 1'b0,
    CFG_TIMEOUT   = 1'b1
  } cfg_idx_t;

  // Per-byte classification
  typedef enum logic [1:0] {
    CLS_MORE     = 2'd0,
    CLS_LINE_END = 2'd1,
    CLS_FULL     = 2'd2
  } byte_class_t;

  // Line read status
  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_PARTIAL  = 2'd1,
    ST_RECEIVED = 2'd2
  } line_status_t;

  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [8:0] MIN_LINE_SIZE = 9'd4;
  localparam logic [8:0] CRLF_LEN      = 9'd2;
  localparam logic [8:0] LINE_SIZE_RST = 9'd256;
  localparam int         NUM_LANES     = 3;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] rx_byte;
    logic [7:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] line_status;
    logic       read_done;
    logic [1:0] byte_class;
    logic [8:0] fill_level;
    logic [7:0] read_data;
  } out_item_t;

  // One buffer write request
  typedef struct packed {
    logic       en;
    logic [8:0] pos;
    logic [7:0] data;
  } wr_lane_t;

endpackage

/* sv/crlf_line_assembler.sv */
`timescale 1ns / 1ps
// Top level: serial byte line assembler with CR/LF detection and ms timeout.
//
// Usage:
//   in_*  : one beat per command (byte received, ms tick, start line read,
//           read entry, clear buffer). Accepted when in_valid && !in_stall.
//   out_* : exactly one result beat per command, in order: line status,
//           read done, byte class, fill level and, for a read, the stored byte.
//   cfg_* : register writes (0 line size, 1 timeout in ms); cfg_ready is
//           always high, so a write lands on any cycle with cfg_valid.
//           Write only while no command is in flight.
// The result is registered and appears the cycle after acceptance.
// One command per cycle while in_stall is low; every state update is done
// in the accepting cycle and the buffer banks take up to three writes at once.
// A read of an entry uses the registered bank output, ready with the result.
// When out_stall holds a waiting result, in_stall rises and no new command
// is taken until that result leaves. Reset clears fill level, pending CR,
// read status and timer and sets line size to 256; buffer contents are not
// cleared and only positions below the fill level are ever read back.
module crlf_line_assembler import cla_pkg::*; #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  // command channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  // configuration channel
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [8:0] SIZE_CAP = (BUFFER_DEPTH > 511) ? 9'd511 : 9'(BUFFER_DEPTH);

  // configuration
  logic [8:0]  line_size_r;
  logic [15:0] timeout_r;

  // line state
  logic [8:0]  fp_r, fp_nxt;
  logic        cr_r, cr_nxt;
  logic [15:0] el_r, el_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        fin_r, fin_nxt;

  // output stage
  logic        out_valid_r;
  logic [1:0]  o_status_r;
  logic        o_done_r;
  logic [1:0]  o_class_r;
  logic [8:0]  o_fill_r;
  logic        o_hit_r;

  logic        accept;
  logic [8:0]  eff_size;
  logic [8:0]  size_m2;
  logic [1:0]  cls;
  logic        rd_en;
  logic        rd_hit;
  logic [7:0]  rd_byte;
  wr_lane_t    lane_a;
  logic        app_en;
  logic [8:0]  app_pos;
  wr_lane_t [NUM_LANES-1:0] lanes;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  // Effective line size clamped to [4, depth], capped at 511
  always_comb begin
    if (line_size_r < MIN_LINE_SIZE) begin
      eff_size = MIN_LINE_SIZE;
    end else if (line_size_r > SIZE_CAP) begin
      eff_size = SIZE_CAP;
    end else begin
      eff_size = line_size_r;
    end
  end
  assign size_m2 = eff_size - CRLF_LEN;

  // Command decode and next state
  always_comb begin
    logic       chk_en;
    logic [8:0] fp_chk;
    logic [8:0] fp_inc;
    logic [15:0] el_inc;
    fp_nxt  = fp_r;
    cr_nxt  = cr_r;
    el_nxt  = el_r;
    st_nxt  = st_r;
    fin_nxt = fin_r;
    cls     = CLS_MORE;
    lane_a  = '0;
    app_en  = 1'b0;
    app_pos = fp_r;
    chk_en  = 1'b0;
    fp_chk  = fp_r;
    fp_inc  = fp_r + 9'd1;
    el_inc  = (el_r != 16'hFFFF) ? el_r + 16'd1 : el_r;
    if (accept) begin
      unique case (in_data.opcode)
        OP_BYTE: begin
          if (cr_r) begin
            cr_nxt = 1'b0;
            if (in_data.rx_byte == CH_LF) begin
              cls = CLS_LINE_END;
              if (fp_r < eff_size) begin
                lane_a.en   = 1'b1;
                lane_a.pos  = fp_r;
                lane_a.data = CH_LF;
                fp_nxt      = fp_inc;
              end
            end else begin
              // overwrite the pending CR
              lane_a.en   = 1'b1;
              lane_a.pos  = fp_r - 9'd1;
              lane_a.data = in_data.rx_byte;
              chk_en      = 1'b1;
              fp_chk      = fp_r;
            end
          end else if (fp_r >= size_m2) begin
            cls = CLS_FULL;
          end else begin
            lane_a.en   = 1'b1;
            lane_a.pos  = fp_r;
            lane_a.data = in_data.rx_byte;
            fp_nxt      = fp_inc;
            if (in_data.rx_byte == CH_CR) begin
              cr_nxt = 1'b1;
            end else begin
              chk_en = 1'b1;
              fp_chk = fp_inc;
            end
          end
          // full check: append CR LF at size minus two
          if (chk_en) begin
            if (fp_chk == size_m2) begin
              app_en  = 1'b1;
              app_pos = fp_chk;
              fp_nxt  = fp_chk + CRLF_LEN;
              cls     = CLS_FULL;
            end else if (fp_chk > size_m2) begin
              cls = CLS_FULL;
            end
          end
          if (!fin_r) begin
            st_nxt = ST_PARTIAL;
            if (cls != CLS_MORE) begin
              st_nxt  = ST_RECEIVED;
              fin_nxt = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (!fin_r) begin
            el_nxt = el_inc;
            if ((timeout_r != '0) && (el_inc >= timeout_r)) begin
              fin_nxt = 1'b1;
            end
          end
        end
        OP_START: begin
          el_nxt  = '0;
          st_nxt  = ST_NONE;
          fin_nxt = 1'b0;
        end
        OP_CLEAR: begin
          fp_nxt = '0;
          cr_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Buffer write lanes: stored byte, appended CR, appended LF
  always_comb begin
    lanes[0]      = lane_a;
    lanes[1].en   = app_en;
    lanes[1].pos  = app_pos;
    lanes[1].data = CH_CR;
    lanes[2].en   = app_en;
    lanes[2].pos  = app_pos + 9'd1;
    lanes[2].data = CH_LF;
  end

  // Entry read
  assign rd_en  = accept && (in_data.opcode == OP_READ);
  assign rd_hit = ({1'b0, in_data.entry_index} < fp_r) &&
                  (32'(in_data.entry_index) < BUFFER_DEPTH);

  cla_line_mem #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_mem (
    .clk      (clk),
    .wr_lanes (lanes),
    .rd_en    (rd_en),
    .rd_index (in_data.entry_index),
    .rd_byte  (rd_byte)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_size_r <= LINE_SIZE_RST;
      timeout_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LINE_SIZE: line_size_r <= cfg_wdata[8:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_wdata;
        default:       line_size_r <= line_size_r;
      endcase
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r  <= '0;
      cr_r  <= 1'b0;
      el_r  <= '0;
      st_r  <= ST_NONE;
      fin_r <= 1'b0;
    end else begin
      fp_r  <= fp_nxt;
      cr_r  <= cr_nxt;
      el_r  <= el_nxt;
      st_r  <= st_nxt;
      fin_r <= fin_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_status_r <= st_nxt;
      o_done_r   <= fin_nxt;
      o_class_r  <= cls;
      o_fill_r   <= fp_nxt;
      o_hit_r    <= rd_en && rd_hit;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data.line_status = o_status_r;
  assign out_data.read_done   = o_done_r;
  assign out_data.byte_class  = o_class_r;
  assign out_data.fill_level  = o_fill_r;
  assign out_data.read_data   = o_hit_r ? rd_byte : 8'd0;

`ifndef SYNTHESIS
  // a pending CR always has its byte stored
  a_cr_has_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cr_r |-> (fp_r != '0))
    else $error("CR pending with empty buffer");

  // a finished read stays finished until a new read starts
  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r && !(accept && (in_data.opcode == OP_START))) |=> fin_r)
    else $error("finished dropped without start");

  // timer frozen once the read has ended
  a_timer_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r && !(accept && (in_data.opcode == OP_START))) |=> $stable(el_r))
    else $error("timer moved after read end");

  // a waiting result blocks new commands
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !accept)
    else $error("command accepted over a held result");
`endif

endmodule

/* sv/cla_line_mem.sv */
`timescale 1ns / 1ps
// Line buffer: four interleaved single-write banks, one registered read port.
module cla_line_mem import cla_pkg::*; #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic                      clk,
  input  wr_lane_t [NUM_LANES-1:0]  wr_lanes,
  input  logic                      rd_en,
  input  logic [7:0]                rd_index,
  output logic [7:0]                rd_byte
);

  localparam int BANK_DEPTH = (BUFFER_DEPTH + 3) / 4;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [3:0]         bank_we;
  logic [3:0][AW-1:0] bank_waddr;
  logic [3:0][7:0]    bank_wdata;
  logic [3:0][7:0]    bank_q_r;
  logic [1:0]         sel_r;
  logic [AW-1:0]      raddr;
  logic [31:0]        raddr_wide;
  logic [7:0]         mem [4][BANK_DEPTH];

  // Route each lane to the bank given by its low position bits.
  // Three consecutive positions always land in three different banks.
  always_comb begin
    logic [31:0] waddr_wide;
    bank_we    = '0;
    bank_waddr = '0;
    bank_wdata = '0;
    waddr_wide = '0;
    for (int b = 0; b < 4; b++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (wr_lanes[l].en && (wr_lanes[l].pos[1:0] == 2'(b)) &&
            (32'(wr_lanes[l].pos) < BUFFER_DEPTH)) begin
          waddr_wide    = 32'(wr_lanes[l].pos[8:2]);
          bank_we[b]    = 1'b1;
          bank_waddr[b] = waddr_wide[AW-1:0];
          bank_wdata[b] = wr_lanes[l].data;
        end
      end
    end
  end

  assign raddr_wide = 32'(rd_index[7:2]);
  assign raddr      = raddr_wide[AW-1:0];

  // Bank storage; bank select follows the read data
  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (bank_we[b]) begin
        mem[b][bank_waddr[b]] <= bank_wdata[b];
      end
      if (rd_en) begin
        bank_q_r[b] <= mem[b][raddr];
      end
    end
    if (rd_en) begin
      sel_r <= rd_index[1:0];
    end
  end

  assign rd_byte = bank_q_r[sel_r];

endmodule
